@@ design/cpot_pkg.sv @@
// ---------------------------------------------------------------------------
// cpot_pkg: shared types for the closest-point-on-triangle pipeline
// region codes, result modes and the control word carried down the pipe
// ---------------------------------------------------------------------------
package cpot_pkg;

  // region of the triangle that holds the closest point
  typedef enum logic [2:0] {
    REGION_VTX_A    = 3'd0,
    REGION_VTX_B    = 3'd1,
    REGION_VTX_C    = 3'd2,
    REGION_EDGE_AB  = 3'd3,
    REGION_EDGE_BC  = 3'd4,
    REGION_EDGE_CA  = 3'd5,
    REGION_INTERIOR = 3'd6
  } region_e;

  // how the output point is formed
  typedef enum logic [1:0] {
    MODE_PICK = 2'd0,
    MODE_EDGE = 2'd1,
    MODE_BARY = 2'd2
  } mode_e;

  // vertex select, for a vertex result and for the start of an edge
  typedef enum logic [1:0] {
    VTX_A = 2'd0,
    VTX_B = 2'd1,
    VTX_C = 2'd2
  } vtx_e;

  typedef struct packed {
    mode_e   mode;
    region_e region;
    logic    deg;
    vtx_e    pick;
    logic    neg_u;
    logic    neg_v;
  } ctl_t;

endpackage

@@ design/closest_point_on_triangle.sv @@
// ---------------------------------------------------------------------------
// closest_point_on_triangle: voronoi-region closest point, fully pipelined
// throughput one word per cycle while m_axis_tready is high or the last stage is empty;
// depth set by the FRAC_BITS-step divider
// async active-low reset clears only the valid bits, the pipe drains empty
// ---------------------------------------------------------------------------
module closest_point_on_triangle #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input word
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata from bit 0: vertex_a_x/y/z, vertex_b_x/y/z, vertex_c_x/y/z,
  // query_x/y/z, each COORD_WIDTH bits, zero padded to whole bytes
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // result word
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // tdata from bit 0: closest_x/y/z, each COORD_WIDTH bits, zero padded
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // tuser from bit 0: region (3 bits), degenerate (1 bit)
  output logic [3:0]                                 m_axis_tuser
);
  import cpot_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int D     = CW + 1;       // coordinate difference
  localparam int PW    = 2 * D;        // product of two differences
  localparam int DOTW  = 2 * D + 2;    // dot product of differences
  localparam int CRW   = 2 * D + 1;    // cross product component
  localparam int H     = D + 1;        // low half of a cross component
  localparam int PPW   = 2 * D + 2;    // partial product
  localparam int VPW   = 4 * D + 2;    // full product of two cross components
  localparam int VW    = 4 * D + 4;    // barycentric volume term
  localparam int SW    = 4 * D + 6;    // divider and decision width
  localparam int WTW   = FB + 3;       // signed weight
  localparam int BMW   = CW + WTW;     // coordinate times weight
  localparam int EMW   = D + WTW;      // edge direction times ratio
  localparam int IW    = CW + WTW + 2; // weighted sum, output path width

  // pipeline stage positions
  localparam int K_DEC = 6;
  localparam int K_P1  = FB + 8;
  localparam int K_P2  = FB + 9;
  localparam int K_P3  = FB + 10;
  localparam int NSTG  = FB + 12;

  // operand tables: differences 0 ab, 1 ac, 2 bc, 3 pa, 4 pb, 5 pc
  // dots: snom, sdenom, tnom, tdenom, unom, udenom (odd ones negated)
  localparam int DOT_L [6] = '{3, 4, 3, 5, 4, 5};
  localparam int DOT_R [6] = '{0, 0, 1, 1, 2, 2};
  localparam bit DOT_NEG [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  // crosses: normal ab x ac, then (a-p)x(b-p), (b-p)x(c-p), (c-p)x(a-p)
  localparam int X_L [4] = '{0, 3, 4, 5};
  localparam int X_R [4] = '{1, 4, 5, 3};
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};
  // volumes va, vb, vc use crosses 2, 3, 1
  localparam int V_CR [3] = '{2, 3, 1};

  localparam logic signed [WTW-1:0] ONE_W  = $signed({3'b001, {FB{1'b0}}});
  localparam logic signed [EMW-1:0] BIAS_E = $signed({{(EMW-FB){1'b0}}, {FB{1'b1}}});
  localparam logic signed [EMW-1:0] ZERO_E = '0;
  localparam logic signed [IW-1:0]  BIAS_I = $signed({{(IW-FB){1'b0}}, {FB{1'b1}}});
  localparam logic signed [IW-1:0]  ZERO_I = '0;
  localparam logic signed [IW-1:0]  MAX_C  = $signed({{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}});
  localparam logic signed [IW-1:0]  MIN_C  = ~MAX_C;

  function automatic logic signed [D-1:0] sdiff(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    return $signed({x[CW-1], x}) - $signed({y[CW-1], y});
  endfunction

  function automatic logic le0(input logic signed [SW-1:0] x);
    return x[SW-1] | ~|x;
  endfunction

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
    return x[SW-1] ? -x : x;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic signed [IW-1:0] x);
    logic signed [IW-1:0] r;
    r = x;
    if (x > MAX_C) r = MAX_C;
    if (x < MIN_C) r = MIN_C;
    return r[CW-1:0];
  endfunction

  // ---- flow control: the whole pipe moves together, one stall point ----
  logic            adv;
  logic            vld_q [NSTG];

  assign adv           = ~vld_q[NSTG-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // ---- unpack; vertex coordinates ride along to the output stage ----
  logic signed [CW-1:0] in_crd [12];
  logic signed [CW-1:0] crd_q [NSTG-1][9];

  always_comb begin
    for (int i = 0; i < 12; i++) in_crd[i] = $signed(s_axis_tdata[i*CW +: CW]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) crd_q[0][j] <= in_crd[j];
      for (int k = 1; k < NSTG-1; k++) crd_q[k] <= crd_q[k-1];
    end
  end

  // ---- stage 0: edge and query differences ----
  logic signed [D-1:0] diff_q [6][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[0][i] <= sdiff(in_crd[3+i], in_crd[i]);
        diff_q[1][i] <= sdiff(in_crd[6+i], in_crd[i]);
        diff_q[2][i] <= sdiff(in_crd[6+i], in_crd[3+i]);
        diff_q[3][i] <= sdiff(in_crd[9+i], in_crd[i]);
        diff_q[4][i] <= sdiff(in_crd[9+i], in_crd[3+i]);
        diff_q[5][i] <= sdiff(in_crd[9+i], in_crd[6+i]);
      end
    end
  end

  // ---- stage 1: all difference products ----
  logic signed [PW-1:0] dprod_q [6][3];
  logic signed [PW-1:0] xprod_q [4][6];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        for (int i = 0; i < 3; i++) dprod_q[k][i] <= diff_q[DOT_L[k]][i] * diff_q[DOT_R[k]][i];
      end
      for (int m = 0; m < 4; m++) begin
        for (int j = 0; j < 3; j++) begin
          xprod_q[m][2*j]   <= diff_q[X_L[m]][NXT1[j]] * diff_q[X_R[m]][NXT2[j]];
          xprod_q[m][2*j+1] <= diff_q[X_L[m]][NXT2[j]] * diff_q[X_R[m]][NXT1[j]];
        end
      end
    end
  end

  // ---- stage 2: dot products and cross products ----
  logic signed [DOTW-1:0] dot_d [6];
  logic signed [DOTW-1:0] dot_q [6];
  logic signed [CRW-1:0]  crs_q [4][3];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dot_d[k] = DOTW'(dprod_q[k][0]) + DOTW'(dprod_q[k][1]) + DOTW'(dprod_q[k][2]);
      if (DOT_NEG[k]) dot_d[k] = -dot_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_q <= dot_d;
      for (int m = 0; m < 4; m++) begin
        for (int j = 0; j < 3; j++) begin
          crs_q[m][j] <= CRW'(xprod_q[m][2*j]) - CRW'(xprod_q[m][2*j+1]);
        end
      end
    end
  end

  // ---- stage 3: normal . cross split into half-width partial products ----
  // partial order: lo*lo (unsigned), hi*lo, lo*hi, hi*hi
  logic signed [PPW-1:0]  pp_d [3][3][4];
  logic signed [PPW-1:0]  pp_q [3][3][4];
  logic signed [DOTW-1:0] dot3_q [6];

  always_comb begin
    logic [H-1:0]        nl, cl;
    logic signed [D-1:0] nh, ch;
    for (int v = 0; v < 3; v++) begin
      for (int j = 0; j < 3; j++) begin
        nl = crs_q[0][j][H-1:0];
        nh = $signed(crs_q[0][j][CRW-1:H]);
        cl = crs_q[V_CR[v]][j][H-1:0];
        ch = $signed(crs_q[V_CR[v]][j][CRW-1:H]);
        pp_d[v][j][0] = PPW'(nl) * PPW'(cl);
        pp_d[v][j][1] = nh * $signed({1'b0, cl});
        pp_d[v][j][2] = $signed({1'b0, nl}) * ch;
        pp_d[v][j][3] = nh * ch;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q   <= pp_d;
      dot3_q <= dot_q;
    end
  end

  // ---- stage 4: recombine partials per component ----
  logic signed [VPW-1:0]  prod_d [3][3];
  logic signed [VPW-1:0]  prod_q [3][3];
  logic signed [DOTW-1:0] dot4_q [6];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[v][j] = (VPW'(pp_q[v][j][3]) << (2*H))
                     + ((VPW'(pp_q[v][j][1]) + VPW'(pp_q[v][j][2])) << H)
                     + VPW'($unsigned(pp_q[v][j][0]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      dot4_q <= dot3_q;
    end
  end

  // ---- stage 5: volumes va, vb, vc ----
  logic signed [VW-1:0]   vol_q [3];
  logic signed [DOTW-1:0] dot5_q [6];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int v = 0; v < 3; v++) begin
        vol_q[v] <= VW'(prod_q[v][0]) + VW'(prod_q[v][1]) + VW'(prod_q[v][2]);
      end
      dot5_q <= dot4_q;
    end
  end

  // ---- stage 6: region decision and divider operands ----
  // vertex tests first, then edges ab, bc, ca, then a flat triangle, then the interior
  logic signed [SW-1:0] dw [6];
  logic signed [SW-1:0] va_w, vb_w, vc_w, sum_w;
  logic signed [SW-1:0] den_ab, den_bc, den_ca;
  ctl_t                 ctl_d;
  logic [SW-1:0]        num_d [2];
  logic [SW-1:0]        den_d;
  ctl_t                 ctl_q [K_DEC:NSTG-2];
  logic [SW-1:0]        num_q [2];
  logic [SW-1:0]        den_q;

  always_comb begin
    for (int k = 0; k < 6; k++) dw[k] = SW'(dot5_q[k]);
    va_w   = SW'(vol_q[0]);
    vb_w   = SW'(vol_q[1]);
    vc_w   = SW'(vol_q[2]);
    sum_w  = va_w + vb_w + vc_w;
    den_ab = dw[0] + dw[1];
    den_ca = dw[2] + dw[3];
    den_bc = dw[4] + dw[5];

    ctl_d.mode   = MODE_PICK;
    ctl_d.region = REGION_VTX_A;
    ctl_d.deg    = 1'b0;
    ctl_d.pick   = VTX_A;
    ctl_d.neg_u  = va_w[SW-1];
    ctl_d.neg_v  = vb_w[SW-1];
    num_d[0]     = mag(va_w);
    num_d[1]     = mag(vb_w);
    den_d        = sum_w;

    if (le0(dw[0]) && le0(dw[2])) begin
      ctl_d.region = REGION_VTX_A;
    end else if (le0(dw[1]) && le0(dw[4])) begin
      ctl_d.region = REGION_VTX_B;
      ctl_d.pick   = VTX_B;
    end else if (le0(dw[3]) && le0(dw[5])) begin
      ctl_d.region = REGION_VTX_C;
      ctl_d.pick   = VTX_C;
    end else if (le0(vc_w) && !dw[0][SW-1] && !dw[1][SW-1]) begin
      if (den_ab == '0) begin
        ctl_d.deg = 1'b1;
      end else begin
        ctl_d.mode   = MODE_EDGE;
        ctl_d.region = REGION_EDGE_AB;
        ctl_d.neg_u  = 1'b0;
        num_d[0]     = dw[0];
        den_d        = den_ab;
      end
    end else if (le0(va_w) && !dw[4][SW-1] && !dw[5][SW-1]) begin
      if (den_bc == '0) begin
        ctl_d.deg = 1'b1;
      end else begin
        ctl_d.mode   = MODE_EDGE;
        ctl_d.region = REGION_EDGE_BC;
        ctl_d.pick   = VTX_B;
        ctl_d.neg_u  = 1'b0;
        num_d[0]     = dw[4];
        den_d        = den_bc;
      end
    end else if (le0(vb_w) && !dw[2][SW-1] && !dw[3][SW-1]) begin
      if (den_ca == '0) begin
        ctl_d.deg = 1'b1;
      end else begin
        ctl_d.mode   = MODE_EDGE;
        ctl_d.region = REGION_EDGE_CA;
        ctl_d.neg_u  = 1'b0;
        num_d[0]     = dw[2];
        den_d        = den_ca;
      end
    end else if (le0(sum_w)) begin
      // flat triangle: fall back to vertex a
      ctl_d.deg = 1'b1;
    end else begin
      ctl_d.mode   = MODE_BARY;
      ctl_d.region = REGION_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[K_DEC] <= ctl_d;
      for (int k = K_DEC+1; k < NSTG-1; k++) ctl_q[k] <= ctl_q[k-1];
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // ---- divider: two restoring lanes sharing one denominator ----
  // lane 0 gives the edge ratio or |u|, lane 1 gives |v|; one quotient bit
  // per stage, ratio saturates to one when the numerator reaches the divisor
  logic [SW-1:0] rem_q [2][FB];
  logic [SW-1:0] dden_q [FB];
  logic          sat_q [2][FB+1];
  logic [FB-1:0] quo_q [2][1:FB];
  logic [SW-1:0] dv_sh [2][1:FB];
  logic          dv_ge [2][1:FB];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int i = 1; i <= FB; i++) begin
        dv_sh[l][i] = {rem_q[l][i-1][SW-2:0], 1'b0};
        dv_ge[l][i] = dv_sh[l][i] >= dden_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dden_q[0] <= den_q;
      for (int i = 1; i < FB; i++) dden_q[i] <= dden_q[i-1];
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= num_q[l];
        sat_q[l][0] <= num_q[l] >= den_q;
        for (int i = 1; i <= FB; i++) sat_q[l][i] <= sat_q[l][i-1];
        quo_q[l][1] <= {{(FB-1){1'b0}}, dv_ge[l][1]};
        for (int i = 2; i <= FB; i++) quo_q[l][i] <= {quo_q[l][i-1][FB-2:0], dv_ge[l][i]};
        for (int i = 1; i < FB; i++) begin
          rem_q[l][i] <= dv_ge[l][i] ? dv_sh[l][i] - dden_q[i-1] : dv_sh[l][i];
        end
      end
    end
  end

  // ---- post 1: signed weights and edge direction ----
  logic signed [WTW-1:0] t_w [2];
  logic signed [WTW-1:0] u_w, v_w;
  logic signed [D-1:0]   dir_d [3];
  logic signed [WTW-1:0] wt_q [3];
  logic signed [D-1:0]   dir_q [3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_w[l] = sat_q[l][FB] ? ONE_W : $signed({3'b000, quo_q[l][FB]});
    end
    u_w = ctl_q[K_P1-1].neg_u ? -t_w[0] : t_w[0];
    v_w = ctl_q[K_P1-1].neg_v ? -t_w[1] : t_w[1];
    for (int i = 0; i < 3; i++) begin
      case (ctl_q[K_P1-1].region)
        REGION_EDGE_BC: dir_d[i] = sdiff(crd_q[K_P1-1][6+i], crd_q[K_P1-1][3+i]);
        REGION_EDGE_CA: dir_d[i] = sdiff(crd_q[K_P1-1][6+i], crd_q[K_P1-1][i]);
        default:        dir_d[i] = sdiff(crd_q[K_P1-1][3+i], crd_q[K_P1-1][i]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wt_q[0] <= u_w;
      wt_q[1] <= v_w;
      wt_q[2] <= ONE_W - u_w - v_w;
      dir_q   <= dir_d;
    end
  end

  // ---- post 2: weight products ----
  logic signed [BMW-1:0] bm_q [3][3];
  logic signed [EMW-1:0] em_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int vx = 0; vx < 3; vx++) begin
        for (int i = 0; i < 3; i++) bm_q[vx][i] <= crd_q[K_P2-1][vx*3+i] * wt_q[vx];
      end
      for (int i = 0; i < 3; i++) em_q[i] <= dir_q[i] * wt_q[0];
    end
  end

  // ---- post 3: weighted sum, edge offset truncated toward zero ----
  logic signed [EMW-1:0] eb [3];
  logic signed [IW-1:0]  isum_q [3];
  logic signed [EMW-1:0] etr_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) eb[i] = em_q[i][EMW-1] ? BIAS_E : ZERO_E;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        isum_q[i] <= IW'(bm_q[0][i]) + IW'(bm_q[1][i]) + IW'(bm_q[2][i]);
        etr_q[i]  <= (em_q[i] + eb[i]) >>> FB;
      end
    end
  end

  // ---- post 4: select, saturate, output register ----
  logic signed [IW-1:0] ib [3];
  logic signed [IW-1:0] bq [3];
  logic signed [IW-1:0] eq [3];
  logic signed [CW-1:0] pk [3];
  logic [CW-1:0]        res_d [3];
  logic [CW-1:0]        out_crd_q [3];
  region_e              out_region_q;
  logic                 out_deg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (ctl_q[K_P3].pick)
        VTX_A:   pk[i] = crd_q[K_P3][i];
        VTX_B:   pk[i] = crd_q[K_P3][3+i];
        VTX_C:   pk[i] = crd_q[K_P3][6+i];
        default: pk[i] = crd_q[K_P3][i];
      endcase
      ib[i] = isum_q[i][IW-1] ? BIAS_I : ZERO_I;
      bq[i] = (isum_q[i] + ib[i]) >>> FB;
      eq[i] = IW'(pk[i]) + IW'(etr_q[i]);
      case (ctl_q[K_P3].mode)
        MODE_EDGE: res_d[i] = clamp(eq[i]);
        MODE_BARY: res_d[i] = clamp(bq[i]);
        default:   res_d[i] = pk[i];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_crd_q    <= res_d;
      out_region_q <= ctl_q[K_P3].region;
      out_deg_q    <= ctl_q[K_P3].deg;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) m_axis_tdata[i*CW +: CW] = out_crd_q[i];
  end

  assign m_axis_tuser = {out_deg_q, out_region_q};

endmodule
